FILE: hdl/mraf_pkg.sv
`default_nettype none
package mraf_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int SIZE_W       = 7;
  localparam int SIZE_RESET   = 64;
  localparam int AREA_W       = 13;
  localparam int AREA_SAT     = 8191;
  localparam int CFG_ADDR_W   = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_SEL,
    ST_NB_CHK,
    ST_REGION_END,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    NB_DOWN,
    NB_RIGHT,
    NB_UP,
    NB_LEFT
  } nb_dir_t;

  typedef struct packed {
    logic load_write;
    logic pos_clear;
    logic pos_step;
    logic best_clear;
    logic scan_read;
    logic start_region;
    logic pop;
    logic latch_top;
    logic nb_read;
    logic nb_step;
    logic push;
    logic region_done;
    logic out_load;
  } mraf_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic cell_land;
    logic nb_valid;
    logic nb_last;
    logic stack_empty;
    logic out_full;
  } mraf_status_t;

endpackage
`default_nettype wire

FILE: hdl/mraf_ram.sv
`default_nettype none
module mraf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mraf_ctrl.sv
`default_nettype none
module mraf_ctrl
  import mraf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         cfg_we,
  input  wire mraf_status_t status,
  output logic              in_ready,
  output mraf_cmd_t         cmd
);

  state_t state, state_next;
  logic   in_fire;

  assign in_ready = (state == ST_LOAD);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_LOAD: begin
        if (cfg_we) begin
          cmd.pos_clear = 1'b1;
        end else if (in_fire) begin
          cmd.load_write = 1'b1;
          if (status.pos_last) begin
            cmd.pos_clear  = 1'b1;
            cmd.best_clear = 1'b1;
            state_next     = ST_SCAN_RD;
          end else begin
            cmd.pos_step = 1'b1;
          end
        end
      end
      ST_SCAN_RD: begin
        cmd.scan_read = 1'b1;
        state_next    = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (status.cell_land) begin
          cmd.start_region = 1'b1;
          state_next       = ST_POP;
        end else if (status.pos_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.pos_step = 1'b1;
          state_next   = ST_SCAN_RD;
        end
      end
      ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        cmd.latch_top = 1'b1;
        state_next    = ST_NB_SEL;
      end
      ST_NB_SEL: begin
        if (status.nb_valid) begin
          cmd.nb_read = 1'b1;
          state_next  = ST_NB_CHK;
        end else if (!status.nb_last) begin
          cmd.nb_step = 1'b1;
        end else if (status.stack_empty) begin
          state_next = ST_REGION_END;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_NB_CHK: begin
        cmd.push = status.cell_land;
        if (!status.nb_last) begin
          cmd.nb_step = 1'b1;
          state_next  = ST_NB_SEL;
        end else if (status.stack_empty && !status.cell_land) begin
          state_next = ST_REGION_END;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_REGION_END: begin
        cmd.region_done = 1'b1;
        if (status.pos_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.pos_step = 1'b1;
          state_next   = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (!status.out_full) begin
          cmd.out_load  = 1'b1;
          cmd.pos_clear = 1'b1;
          state_next    = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/mraf_dp.sv
`default_nettype none
module mraf_dp
  import mraf_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mraf_cmd_t             cmd,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [SIZE_W-1:0]     cfg_wdata,
  input  wire logic                  land_cell,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic      [AREA_W-1:0]     max_area,
  output mraf_status_t               status
);

  localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
  localparam int IDX_W    = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
  localparam int CNT_W    = $clog2(CELL_CAP + 1);
  localparam int RI_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CI_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SE_W     = IDX_W + RI_W + CI_W;
  localparam int ROW_RST  = ((SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET) - 1;
  localparam int COL_RST  = ((SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET) - 1;

  logic [RI_W-1:0]  row_last, row_last_cfg;
  logic [CI_W-1:0]  col_last, col_last_cfg;
  logic [IDX_W-1:0] pos_idx;
  logic [RI_W-1:0]  pos_row;
  logic [CI_W-1:0]  pos_col;
  logic [IDX_W-1:0] cur_idx;
  logic [RI_W-1:0]  cur_row;
  logic [CI_W-1:0]  cur_col;
  nb_dir_t          nb_k;
  logic [IDX_W-1:0] nb_idx;
  logic [RI_W-1:0]  nb_row;
  logic [CI_W-1:0]  nb_col;
  logic             nb_valid;
  logic [IDX_W-1:0] cols_ext;
  logic [CNT_W-1:0] depth, depth_m1;
  logic [CNT_W-1:0] region_area;
  logic [CNT_W-1:0] best_area;
  logic [AREA_W-1:0] area_sat;

  logic             cell_we, cell_re, cell_wdata, cell_rdata;
  logic [IDX_W-1:0] cell_waddr, cell_raddr;
  logic             stk_we;
  logic [SE_W-1:0]  stk_wdata, stk_rdata;

  // size registers hold count minus one, clamped to the supported range
  always_comb begin
    if (cfg_wdata == '0) begin
      row_last_cfg = '0;
    end else if (int'(cfg_wdata) > MAX_ROWS) begin
      row_last_cfg = RI_W'(MAX_ROWS - 1);
    end else begin
      row_last_cfg = RI_W'(cfg_wdata - SIZE_W'(1));
    end
    if (cfg_wdata == '0) begin
      col_last_cfg = '0;
    end else if (int'(cfg_wdata) > MAX_COLS) begin
      col_last_cfg = CI_W'(MAX_COLS - 1);
    end else begin
      col_last_cfg = CI_W'(cfg_wdata - SIZE_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_last <= RI_W'(ROW_RST);
      col_last <= CI_W'(COL_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_NUM_ROWS: row_last <= row_last_cfg;
        REG_NUM_COLS: col_last <= col_last_cfg;
      endcase
    end
  end

  // row-major position, shared by load and scan
  always_ff @(posedge clk) begin
    if (rst || cmd.pos_clear) begin
      pos_idx <= '0;
      pos_row <= '0;
      pos_col <= '0;
    end else if (cmd.pos_step) begin
      pos_idx <= pos_idx + IDX_W'(1);
      if (pos_col == col_last) begin
        pos_col <= '0;
        pos_row <= pos_row + RI_W'(1);
      end else begin
        pos_col <= pos_col + CI_W'(1);
      end
    end
  end

  assign cols_ext = IDX_W'(col_last) + IDX_W'(1);

  always_comb begin
    nb_idx   = cur_idx;
    nb_row   = cur_row;
    nb_col   = cur_col;
    nb_valid = 1'b0;
    unique case (nb_k)
      NB_DOWN: begin
        nb_valid = (cur_row != row_last);
        nb_idx   = cur_idx + cols_ext;
        nb_row   = cur_row + RI_W'(1);
      end
      NB_RIGHT: begin
        nb_valid = (cur_col != col_last);
        nb_idx   = cur_idx + IDX_W'(1);
        nb_col   = cur_col + CI_W'(1);
      end
      NB_UP: begin
        nb_valid = (cur_row != '0);
        nb_idx   = cur_idx - cols_ext;
        nb_row   = cur_row - RI_W'(1);
      end
      NB_LEFT: begin
        nb_valid = (cur_col != '0);
        nb_idx   = cur_idx - IDX_W'(1);
        nb_col   = cur_col - CI_W'(1);
      end
    endcase
  end

  // grid store: cells are cleared as they are pushed
  assign cell_we    = cmd.load_write || cmd.start_region || cmd.push;
  assign cell_waddr = cmd.push ? nb_idx : pos_idx;
  assign cell_wdata = cmd.load_write ? land_cell : 1'b0;
  assign cell_re    = cmd.scan_read || cmd.nb_read;
  assign cell_raddr = cmd.scan_read ? pos_idx : nb_idx;

  mraf_ram #(
    .WIDTH(1),
    .DEPTH(CELL_CAP)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .re   (cell_re),
    .raddr(cell_raddr),
    .rdata(cell_rdata)
  );

  assign depth_m1  = depth - CNT_W'(1);
  assign stk_we    = cmd.start_region || cmd.push;
  assign stk_wdata = cmd.start_region ? {pos_idx, pos_row, pos_col}
                                      : {nb_idx, nb_row, nb_col};

  mraf_ram #(
    .WIDTH(SE_W),
    .DEPTH(CELL_CAP)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(depth[IDX_W-1:0]),
    .wdata(stk_wdata),
    .re   (cmd.pop),
    .raddr(depth_m1[IDX_W-1:0]),
    .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_top) begin
      {cur_idx, cur_row, cur_col} <= stk_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_k        <= NB_DOWN;
      depth       <= '0;
      region_area <= '0;
      best_area   <= '0;
    end else begin
      if (cmd.latch_top) begin
        nb_k <= NB_DOWN;
      end else if (cmd.nb_step) begin
        nb_k <= nb_dir_t'(nb_k + 2'd1);
      end
      if (cmd.start_region) begin
        depth       <= CNT_W'(1);
        region_area <= CNT_W'(1);
      end else if (cmd.push) begin
        depth       <= depth + CNT_W'(1);
        region_area <= region_area + CNT_W'(1);
      end else if (cmd.pop) begin
        depth <= depth_m1;
      end
      if (cmd.best_clear) begin
        best_area <= '0;
      end else if (cmd.region_done && (region_area > best_area)) begin
        best_area <= region_area;
      end
    end
  end

  assign area_sat = (int'(best_area) > AREA_SAT) ? AREA_W'(AREA_SAT) : AREA_W'(best_area);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      max_area <= area_sat;
    end
  end

  assign status.pos_last    = (pos_row == row_last) && (pos_col == col_last);
  assign status.cell_land   = cell_rdata;
  assign status.nb_valid    = nb_valid;
  assign status.nb_last     = (nb_k == NB_LEFT);
  assign status.stack_empty = (depth == '0);
  assign status.out_full    = out_valid;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CNT_W'(CELL_CAP))
    else $error("flood stack beyond grid capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> depth != '0)
    else $error("pop from empty flood stack");

  a_area_covers_stack: assert property (@(posedge clk) disable iff (rst)
    region_area >= depth)
    else $error("region area below stack depth");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid)
    else $error("result register overwritten");

endmodule
`default_nettype wire

FILE: hdl/max_region_area_finder.sv
// Largest 4-connected land region of a binary grid.
// Slave stream: one cell per beat in row-major order, s_tdata[0] = land_cell.
// The grid is num_rows by num_cols (config indexes 0 and 1; 0 reads as 1,
// values above MAX_ROWS / MAX_COLS read as the maximum). Any config write
// restarts the load at the first cell.
// Loading takes one cell per cycle while no config write is made. The beat
// with the last cell starts the search, during which s_tready is low. The
// search reads and checks each scanned cell; each land cell is popped from
// the flood stack, then each neighbor is selected and, when in the grid,
// read, and each region ends with a closing step. Both the grid store and
// the stack are dual-port RAMs (one write, one read port), registered reads.
// Master stream: one beat per grid, m_tdata[12:0] = max_area (saturates at
// 8191). The result sits in an output register; the next grid loads while it
// waits. If a second result is ready before the first is taken, the search
// holds until m_tready drains the register.
// Reset (synchronous) returns sizes to 64 by 64 and empties all pipelines.
`default_nettype none
module max_region_area_finder
  import mraf_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [0] land_cell
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [15:0]           m_tdata,   // [12:0] max_area
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [SIZE_W-1:0]     cfg_wdata
);

  mraf_cmd_t         cmd;
  mraf_status_t      status;
  logic [AREA_W-1:0] max_area;

  mraf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .cfg_we  (cfg_we),
    .status  (status),
    .in_ready(s_tready),
    .cmd     (cmd)
  );

  mraf_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .land_cell(s_tdata[0]),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .max_area (max_area),
    .status   (status)
  );

  assign m_tdata = {(16 - AREA_W)'(0), max_area};

endmodule
`default_nettype wire

FILE: test/max_region_area_finder_test.sv
`timescale 1ns / 100ps
module max_region_area_finder_test;
  import mraf_pkg::*;

  localparam int CELL_CAP = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int LIMIT    = 1000000;

  class region_board;
    logic [SIZE_W-1:0] rows_raw;
    logic [SIZE_W-1:0] cols_raw;
    bit                grid[CELL_CAP];
    bit                work[CELL_CAP];
    int unsigned       walk[CELL_CAP];
    int unsigned       depth;
    int unsigned       area;
    int unsigned       loaded;
    int unsigned       cells_in;
    logic [AREA_W-1:0] areas_due[$];
    int                errors;

    function new();
      rows_raw = SIZE_RESET;
      cols_raw = SIZE_RESET;
      loaded   = 0;
      cells_in = 0;
      errors   = 0;
    endfunction

    function int unsigned span(logic [SIZE_W-1:0] raw, int unsigned cap);
      if (raw == 0) return 1;
      if (raw > cap) return cap;
      return raw;
    endfunction

    function int unsigned rows();
      return span(rows_raw, DEF_MAX_ROWS);
    endfunction

    function int unsigned cols();
      return span(cols_raw, DEF_MAX_COLS);
    endfunction

    function int unsigned total();
      return rows() * cols();
    endfunction

    function int pending();
      return areas_due.size();
    endfunction

    // any size write restarts the load
    function void set_size(cfg_reg_t idx, logic [SIZE_W-1:0] v);
      if (idx == REG_NUM_ROWS) rows_raw = v;
      else cols_raw = v;
      loaded = 0;
    endfunction

    function void try_push(int unsigned i);
      if (work[i]) begin
        work[i] = 1'b0;
        walk[depth] = i;
        depth++;
        area++;
      end
    endfunction

    function int unsigned largest_region();
      int unsigned nr, nc, best, idx, r, c;
      nr   = rows();
      nc   = cols();
      best = 0;
      for (int i = 0; i < CELL_CAP; i++) work[i] = grid[i];
      for (int unsigned s = 0; s < nr * nc; s++) begin
        if (work[s]) begin
          area  = 0;
          depth = 0;
          try_push(s);
          while (depth > 0) begin
            depth--;
            idx = walk[depth];
            r = idx / nc;
            c = idx % nc;
            if (r + 1 < nr) try_push(idx + nc);
            if (c + 1 < nc) try_push(idx + 1);
            if (r > 0) try_push(idx - nc);
            if (c > 0) try_push(idx - 1);
          end
          if (area > best) best = area;
        end
      end
      return best;
    endfunction

    function void note_cell(bit land);
      int unsigned best;
      cells_in++;
      if (loaded < CELL_CAP) grid[loaded] = land;
      loaded++;
      if (loaded >= total()) begin
        loaded = 0;
        best = largest_region();
        if (best > AREA_SAT) best = AREA_SAT;
        areas_due.push_back(best[AREA_W-1:0]);
      end
    endfunction

    function void check_area(logic [AREA_W-1:0] got);
      logic [AREA_W-1:0] want;
      if (areas_due.size() == 0) begin
        $display("%0t: max_area expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = areas_due.pop_front();
        if (got !== want) begin
          $display("%0t: max_area expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = 8'd0;   // [0] land_cell
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [15:0]           m_tdata;            // [12:0] max_area
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [SIZE_W-1:0]     cfg_wdata = '0;

  region_board board = new();
  bit          quiet = 1'b0;
  int          hold_len = 0;

  max_region_area_finder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("FAIL max_region_area_finder");
    $finish;
  end

  // result side; ready is stable mid-cycle, the beat lands on the next edge
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) board.check_area(m_tdata[AREA_W-1:0]);
    end
  end

  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_cell(input bit land);
    bit rdy;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, land};
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    board.note_cell(land);
  endtask

  task automatic send_cells(input int unsigned pct, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_cell($urandom_range(0, 99) < pct);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(input cfg_reg_t idx, input logic [SIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_size(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] c);
    write_size(REG_NUM_ROWS, r);
    write_size(REG_NUM_COLS, c);
  endtask

  initial begin
    int unsigned       pct, grids, phase;
    int                sel;
    logic [SIZE_W-1:0] r, c;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single cell, water then land
    set_grid(1, 1);
    send_cell(1'b0);
    send_cell(1'b1);
    settle();
    // zero size reads as one
    set_grid(0, 3);
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b1);
    settle();
    // partial load dropped by a size write
    set_grid(2, 2);
    send_cell(1'b1);
    send_cell(1'b1);
    settle();
    write_size(REG_NUM_COLS, 2);
    repeat (4) send_cell(1'b1);
    settle();
    // checkerboard: diagonals do not connect
    set_grid(3, 3);
    for (int i = 0; i < 9; i++) send_cell(i % 2 == 0);
    settle();

    phase = 0;
    while (board.cells_in < 560) begin
      quiet = (board.cells_in > 450) ? 1'b1 : ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0) r = 0;
      else if (sel == 1) r = $urandom_range(65, 127);
      else r = $urandom_range(1, 8);
      sel = $urandom_range(0, 9);
      if (r > 8) c = $urandom_range(0, 3);
      else if (sel == 0) c = 0;
      else if (sel == 1 && r <= 2) c = $urandom_range(65, 127);
      else c = $urandom_range(1, 8);
      pct = $urandom_range(0, 4) * 25;
      if (phase == 1) begin
        // sink holds off while grids keep coming
        set_grid(2, 2);
        hold_len = 1500;
        repeat (8) send_cells(pct, 4);
      end else begin
        set_grid(r, c);
        grids = (board.total() > 64) ? 1 : $urandom_range(1, 6);
        repeat (grids) send_cells(pct, board.total());
        if ($urandom_range(0, 4) == 0 && board.total() > 1)
          send_cells(pct, $urandom_range(1, board.total() - 1));
      end
      settle();
      phase++;
    end

    quiet = 1'b1;
    set_grid(127, 1);
    send_cells(50, 64);
    settle();
    set_grid(1, 100);
    send_cells(50, 64);
    settle();
    set_grid(2, 64);
    send_cells(100, 128);
    settle();
    repeat (200) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS max_region_area_finder");
    end else begin
      $display("FAIL max_region_area_finder");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mraf_pkg.sv
hdl/mraf_ram.sv
hdl/mraf_ctrl.sv
hdl/mraf_dp.sv
hdl/max_region_area_finder.sv
test/max_region_area_finder_test.sv
